@@ hdl/imuf_pkg.sv @@
// imuf_pkg: shared constants, types and helpers for the IMU serial frame decoder.
// No dependencies; imported by imuf_scale, imu_serial_frame_decoder_top and the bench.
package imuf_pkg;

   localparam logic [7:0] HDR_BYTE   = 8'h55;
   localparam logic [7:0] TYPE_ACC   = 8'h51;
   localparam logic [7:0] TYPE_RATE  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;

   localparam logic [1:0] KIND_ACC   = 2'd0;
   localparam logic [1:0] KIND_RATE  = 2'd1;
   localparam logic [1:0] KIND_ANGLE = 2'd2;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 17;   // 16-bit word plus sign, covers signed and unsigned words
   localparam int SCALE_W = 12;
   localparam int AXIS_W  = 27;
   localparam int PROD_W  = WORD_W + SCALE_W;
   localparam int RSP_W   = 88;   // 2 + 3*27 = 83 bits, padded to whole bytes

   localparam logic signed [SCALE_W-1:0] SCALE_ACC   = 12'sd16;
   localparam logic signed [SCALE_W-1:0] SCALE_RATE  = 12'sd2000;
   localparam logic signed [SCALE_W-1:0] SCALE_ANGLE = 12'sd180;

   typedef struct packed {
      logic [1:0]               kind;
      logic signed [WORD_W-1:0] word_x;
      logic signed [WORD_W-1:0] word_y;
      logic signed [WORD_W-1:0] word_z;
   } frame_type;

   function automatic logic signed [SCALE_W-1:0] scale_of(input logic [1:0] kind);
      logic signed [SCALE_W-1:0] s;
      unique case (kind)
         KIND_ACC:   s = SCALE_ACC;
         KIND_RATE:  s = SCALE_RATE;
         KIND_ANGLE: s = SCALE_ANGLE;
         default:    s = '0;
      endcase
      return s;
   endfunction

endpackage

@@ hdl/imu_serial_frame_decoder_top.sv @@
// imu_serial_frame_decoder_top: IMU serial frame parser with additive checksum.
// Depends on imuf_pkg, imuf_byte_cell and imuf_scale.
//
// Usage:
//   req_*  one received serial byte per request. Any byte is taken while the block
//          waits for header 0x55; after the header the next FRAME_LEN-1 bytes
//          complete the frame, with no resync inside a frame.
//   rsp_*  one request per good frame (checksum matches, type 0x51/0x52/0x53):
//          frame kind and three axis values scaled by 16, 2000 or 180, 15 fraction
//          bits. Bad or unknown frames produce nothing.
// Throughput: one byte per cycle while req_tready is high. Bytes shift through a row
//   of FRAME_LEN-1 byte cells while a running sum tracks the checksum.
// Result path: on the checksum byte a good frame is captured in the decode register,
//   then multiplied into the output register.
// Stall: bytes keep flowing while a result waits in the output register; req_tready
//   drops only when both the decode register and the output register are full.
// Reset: synchronous, active high; returns to header search, clears valid flags.
//   The byte cells are not reset.
module imu_serial_frame_decoder_top #(
   parameter int FRAME_LEN = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata    // [1:0] frame_kind, [28:2] axis_x, [55:29] axis_y,
                                    // [82:56] axis_z, [87:83] zero
);
   import imuf_pkg::*;

   localparam int NCELL = FRAME_LEN - 1;
   localparam int CNT_W = $clog2(FRAME_LEN);
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);

   logic             req_acc;
   logic             is_hdr;
   logic             last_byte;
   logic             shift_en;
   logic             in_frame_ff, in_frame_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;

   logic [7:0] cell_q [NCELL];
   logic [7:0] db [8];

   logic       known;
   logic [1:0] kind;
   logic       sgn;

   logic      s1_valid_ff, s1_valid_in;
   frame_type s1_ff, s1_in;
   logic      s1_take;

   assign req_acc   = req_tvalid & req_tready;
   assign is_hdr    = (req_tdata == HDR_BYTE);
   assign last_byte = in_frame_ff & (count_ff == LAST_IDX);
   assign shift_en  = req_acc & (in_frame_ff | is_hdr) & ~last_byte;

   // byte shift line: newest byte in cell 0, header ends up in the far cell
   genvar k;
   generate
      for (k = 0; k < NCELL; k++) begin : g_cell
         if (k == 0) begin : g_head
            imuf_byte_cell u_cell (
               .clock    (clock),
               .shift_en (shift_en),
               .byte_in  (req_tdata),
               .byte_out (cell_q[k])
            );
         end else begin : g_body
            imuf_byte_cell u_cell (
               .clock    (clock),
               .shift_en (shift_en),
               .byte_in  (cell_q[k-1]),
               .byte_out (cell_q[k])
            );
         end
      end
      // frame byte i sits in cell NCELL-1-i; indexes at or past the checksum read zero
      for (k = 0; k < 8; k++) begin : g_db
         if (k < NCELL) begin : g_have
            assign db[k] = cell_q[NCELL-1-k];
         end else begin : g_none
            assign db[k] = 8'h00;
         end
      end
   endgenerate

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      if (req_acc) begin
         if (!in_frame_ff) begin
            if (is_hdr) begin
               in_frame_in = 1'b1;
               count_in    = CNT_W'(1);
               sum_in      = HDR_BYTE;
            end
         end else if (last_byte) begin
            in_frame_in = 1'b0;
            count_in    = '0;
         end else begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_ff + req_tdata;
         end
      end
   end

   always_comb begin
      known = 1'b1;
      kind  = KIND_ACC;
      unique case (db[1])
         TYPE_ACC:   kind = KIND_ACC;
         TYPE_RATE:  kind = KIND_RATE;
         TYPE_ANGLE: kind = KIND_ANGLE;
         default:    known = 1'b0;
      endcase
   end

   assign sgn = (kind != KIND_ANGLE);

   always_comb begin
      s1_in.kind   = kind;
      s1_in.word_x = {sgn & db[3][7], db[3], db[2]};
      s1_in.word_y = {sgn & db[5][7], db[5], db[4]};
      s1_in.word_z = {sgn & db[7][7], db[7], db[6]};
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc && last_byte && (sum_ff == req_tdata) && known) begin
         s1_valid_in = 1'b1;
      end else if (s1_take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (req_acc && last_byte) begin
         s1_ff <= s1_in;
      end
   end

   assign req_tready = ~s1_valid_ff | s1_take;

   imuf_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .frm_valid  (s1_valid_ff),
      .frm        (s1_ff),
      .frm_take   (s1_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_IDX)
      else $error("byte count past frame end");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> count_ff == '0)
      else $error("byte count nonzero while waiting for header");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_take |=> s1_valid_ff && $stable(s1_ff))
      else $error("decoded frame lost while output stalled");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      req_acc && last_byte |=> !in_frame_ff)
      else $error("frame did not close after checksum byte");

   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> s1_ff.kind != 2'd3)
      else $error("decoded frame with unused kind");

endmodule

@@ hdl/imuf_byte_cell.sv @@
// imuf_byte_cell: one stage of the frame byte shift line.
// Holds one received byte and passes it to the next cell on each shift. No dependencies.
module imuf_byte_cell (
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] byte_in,
   output logic [7:0] byte_out
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_mux;

   assign byte_in_mux = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_mux;
   end

   assign byte_out = byte_ff;

endmodule

@@ hdl/imuf_scale.sv @@
// imuf_scale: multiplies the three axis words by the frame's scale and holds the
// result in the output register. Depends on imuf_pkg.
module imuf_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                frm_valid,
   input  imuf_pkg::frame_type frm,
   output logic                frm_take,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [87:0]         rsp_tdata
);
   import imuf_pkg::*;

   logic signed [SCALE_W-1:0] scale;
   logic signed [PROD_W-1:0]  prod_x;
   logic signed [PROD_W-1:0]  prod_y;
   logic signed [PROD_W-1:0]  prod_z;

   logic              valid_ff, valid_in;
   logic [1:0]        kind_ff;
   logic [AXIS_W-1:0] x_ff, y_ff, z_ff;

   assign scale  = scale_of(frm.kind);
   assign prod_x = PROD_W'(frm.word_x) * PROD_W'(scale);
   assign prod_y = PROD_W'(frm.word_y) * PROD_W'(scale);
   assign prod_z = PROD_W'(frm.word_z) * PROD_W'(scale);

   // output register frees up when empty or being taken this cycle
   assign frm_take = frm_valid & (~valid_ff | rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      if (frm_take) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frm_take) begin
         kind_ff <= frm.kind;
         x_ff    <= prod_x[AXIS_W-1:0];
         y_ff    <= prod_y[AXIS_W-1:0];
         z_ff    <= prod_z[AXIS_W-1:0];
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'b0, z_ff, y_ff, x_ff, kind_ff};

endmodule

@@ tb/imu_serial_frame_decoder_top_test.sv @@
// Self-checking testbench for imu_serial_frame_decoder_top: serial byte frames in,
// scaled axis requests out, compared against an in-bench frame decoder.
// Depends on imuf_pkg and the decoder RTL.
`timescale 1ns / 100ps

module imu_serial_frame_decoder_top_test;
   import imuf_pkg::*;

   localparam int FRAME_LEN = 11;
   localparam int AXIS_BITS = 27;

   typedef struct {
      logic [1:0]                  kind;
      logic signed [AXIS_BITS-1:0] x;
      logic signed [AXIS_BITS-1:0] y;
      logic signed [AXIS_BITS-1:0] z;
   } axis_sample_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;           // [1:0] frame_kind, [28:2] axis_x, [55:29] axis_y,
                                     // [82:56] axis_z, [87:83] zero

   axis_sample_type pending_axes[$];
   int           mismatch_count = 0;
   int           frame_bytes_sent = 0;
   bit           pace_on = 1'b1;     // random gaps on both sides when set
   int           long_hold = 0;      // receiver hold-off request, in cycles

   // shadow of the decoder state
   bit          frame_open = 1'b0;
   int          fill_idx = 0;
   logic [7:0]  frame_store [0:15];

   imu_serial_frame_decoder_top #(.FRAME_LEN(FRAME_LEN)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // bytes at the checksum slot or beyond read as zero on short frames
   function automatic logic [7:0] store_byte(int idx);
      if (idx >= FRAME_LEN - 1 || idx >= 16)
         return 8'h00;
      return frame_store[idx];
   endfunction

   function automatic logic signed [AXIS_BITS-1:0] scaled_axis(int idx, bit is_signed,
                                                               int scale);
      logic [15:0]  w;
      int           wv;
      logic [63:0]  prod;
      w = {store_byte(idx + 1), store_byte(idx)};
      wv = is_signed ? int'($signed(w)) : int'(w);
      prod = 64'(longint'(wv) * longint'(scale));
      return prod[AXIS_BITS-1:0];
   endfunction

   function automatic void decode_rx_byte(logic [7:0] b);
      logic [7:0]   sum;
      axis_sample_type s;
      bit           sgn;
      int           scale;
      if (!frame_open) begin
         if (b == HDR_BYTE) begin
            frame_store[0] = b;
            fill_idx = 1;
            frame_open = 1'b1;
         end
         return;
      end
      frame_store[fill_idx & 15] = b;
      if (fill_idx < FRAME_LEN - 1) begin
         fill_idx++;
         return;
      end
      frame_open = 1'b0;
      fill_idx = 0;
      sum = 8'h00;
      for (int i = 0; i < ((FRAME_LEN - 1) & 15); i++)
         sum += frame_store[i];
      if (sum != frame_store[(FRAME_LEN - 1) & 15])
         return;
      case (store_byte(1))
         TYPE_ACC: begin
            s.kind = KIND_ACC; scale = int'(SCALE_ACC); sgn = 1'b1;
         end
         TYPE_RATE: begin
            s.kind = KIND_RATE; scale = int'(SCALE_RATE); sgn = 1'b1;
         end
         TYPE_ANGLE: begin
            s.kind = KIND_ANGLE; scale = int'(SCALE_ANGLE); sgn = 1'b0;
         end
         default: return;
      endcase
      s.x = scaled_axis(2, sgn, scale);
      s.y = scaled_axis(4, sgn, scale);
      s.z = scaled_axis(6, sgn, scale);
      pending_axes.push_back(s);
   endfunction

   // caller sits at a rising edge; valid stays up across back-to-back bytes
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pace_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      decode_rx_byte(b);
   endtask

   task automatic send_frame(input logic [7:0] type_byte, input logic [15:0] wx,
                             input logic [15:0] wy, input logic [15:0] wz,
                             input logic [7:0] sum_err);
      logic [7:0] fb [0:15];
      logic [7:0] sum;
      for (int i = 0; i < 16; i++)
         fb[i] = 8'($urandom_range(0, 255));
      fb[0] = HDR_BYTE;
      fb[1] = type_byte;
      fb[2] = wx[7:0]; fb[3] = wx[15:8];
      fb[4] = wy[7:0]; fb[5] = wy[15:8];
      fb[6] = wz[7:0]; fb[7] = wz[15:8];
      sum = 8'h00;
      for (int i = 0; i < FRAME_LEN - 1; i++)
         sum += fb[i];
      fb[FRAME_LEN - 1] = sum ^ sum_err;
      for (int i = 0; i < FRAME_LEN; i++)
         send_byte(fb[i]);
      frame_bytes_sent += FRAME_LEN;
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_axes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'hFFFF;
         3:       return 16'h0000;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [7:0] pick_type();
      case ($urandom_range(0, 2))
         0:       return TYPE_ACC;
         1:       return TYPE_RATE;
         default: return TYPE_ANGLE;
      endcase
   endfunction

   task automatic test_directed();
      send_byte(8'h00);   // idle noise, ignored
      send_byte(8'hFF);
      send_byte(8'hAA);
      send_frame(TYPE_ACC,   16'h8000, 16'h7FFF, 16'h0000, 8'h00);
      send_frame(TYPE_RATE,  16'h7FFF, 16'h8000, 16'hFFFF, 8'h00);
      send_frame(TYPE_ANGLE, 16'hFFFF, 16'h8000, 16'h0001, 8'h00);
      send_frame(TYPE_ACC,   16'h1234, 16'h5678, 16'h9ABC, 8'h01);   // bad checksum
      send_frame(8'h50,      16'h1111, 16'h2222, 16'h3333, 8'h00);   // unknown type
      send_frame(TYPE_RATE,  16'h5555, 16'h0055, 16'h5500, 8'h00);   // header value as data
      wait_for_drain();
   endtask

   task automatic test_random_traffic();
      logic [7:0] t;
      int         r;
      while (frame_bytes_sent < 2000) begin
         pace_on = ($urandom_range(0, 7) != 0);
         r = $urandom_range(0, 99);
         if (r < 75) begin
            send_frame(pick_type(), pick_word(), pick_word(), pick_word(), 8'h00);
         end else if (r < 83) begin
            send_frame(pick_type(), pick_word(), pick_word(), pick_word(),
                       8'($urandom_range(1, 255)));
         end else if (r < 89) begin
            do t = 8'($urandom_range(0, 255));
            while (t == TYPE_ACC || t == TYPE_RATE || t == TYPE_ANGLE);
            send_frame(t, pick_word(), pick_word(), pick_word(), 8'h00);
         end else if (r < 95) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            // truncated frame; the next frame's bytes land inside it
            send_byte(HDR_BYTE);
            repeat ($urandom_range(1, FRAME_LEN - 2)) send_byte(8'($urandom_range(0, 255)));
         end
      end
      pace_on = 1'b1;
      wait_for_drain();
   endtask

   task automatic test_output_stall();
      pace_on = 1'b0;
      long_hold = 400;
      repeat (12)
         send_frame(pick_type(), pick_word(), pick_word(), pick_word(), 8'h00);
      pace_on = 1'b1;
      wait_for_drain();
   endtask

   // receiver: random hold per request, plus long hold-offs on demand
   initial begin : rsp_pacer
      int n;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold > 0) begin
            n = long_hold;
            long_hold = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         n = pace_on ? $urandom_range(0, 10) : 0;
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid && long_hold == 0);
      end
   end

   task automatic report_mismatch(input string field, input longint want,
                                  input longint got);
      $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : rsp_check
      axis_sample_type got;
      axis_sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tdata[1:0];
         got.x    = rsp_tdata[28:2];
         got.y    = rsp_tdata[55:29];
         got.z    = rsp_tdata[82:56];
         if (pending_axes.size() == 0) begin
            $display("%0t ns: unexpected request, expected none actual kind %0d",
                     $time, got.kind);
            mismatch_count++;
         end else begin
            want = pending_axes.pop_front();
            if (got.kind !== want.kind)
               report_mismatch("frame_kind", longint'(want.kind), longint'(got.kind));
            if (got.x !== want.x)
               report_mismatch("axis_x", longint'(want.x), longint'(got.x));
            if (got.y !== want.y)
               report_mismatch("axis_y", longint'(want.y), longint'(got.y));
            if (got.z !== want.z)
               report_mismatch("axis_z", longint'(want.z), longint'(got.z));
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_output_stall();
      test_random_traffic();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_axes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/imuf_pkg.sv
hdl/imuf_byte_cell.sv
hdl/imuf_scale.sv
hdl/imu_serial_frame_decoder_top.sv
tb/imu_serial_frame_decoder_top_test.sv
